// ===== hdl/rsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RFFE-style serial bus master.
// No dependencies; used by the front end, request queue, engine and top level.
package rsm_pkg;

  // Raw command codes on the request channel
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  // Register indexes on the APB port (byte address bit 2)
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_STOP_HOLD   = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd4;
  localparam logic [15:0] STOP_HOLD_RST   = 16'd16;

  // Frame lengths in bits, parity included
  localparam logic [3:0] START_BITS = 4'd13;
  localparam logic [3:0] BYTE_BITS  = 4'd9;

  // Request queue between front end and engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_START,
    KIND_WRITE,
    KIND_READ,
    KIND_STOP
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [11:0] command_word;
    logic [7:0]  write_data;
    logic        first_of_burst;
    logic        sdata_in;
  } req_t;

  typedef struct packed {
    logic        sclk_level;
    logic        sdata_level;
    logic        sdata_drive;
    logic        busy_res;
    logic        accepted;
    logic [7:0]  read_result;
    logic        read_valid;
    logic        parity_error;
  } res_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] stop_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic drv;
    logic dat;
    logic clk;
  } pins_t;

endpackage

// ===== hdl/rsm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and per-tick results.
// No dependencies.
interface rsm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [11:0] command_word;
  logic [7:0]  write_data;
  logic        first_of_burst;
  logic        sdata_in;

  modport source (
    output valid, command, command_word, write_data, first_of_burst, sdata_in,
    input  ready
  );
  modport sink (
    input  valid, command, command_word, write_data, first_of_burst, sdata_in,
    output ready
  );
endinterface

interface rsm_res_if;
  logic       valid;
  logic       ready;
  logic       sclk_level;
  logic       sdata_level;
  logic       sdata_drive;
  logic       busy_res;
  logic       accepted;
  logic [7:0] read_result;
  logic       read_valid;
  logic       parity_error;

  modport source (
    output valid, sclk_level, sdata_level, sdata_drive, busy_res, accepted,
           read_result, read_valid, parity_error,
    input  ready
  );
  modport sink (
    input  valid, sclk_level, sdata_level, sdata_drive, busy_res, accepted,
           read_result, read_valid, parity_error,
    output ready
  );
endinterface

// ===== hdl/rsm_cfg.sv =====
`timescale 1ns / 1ps
// APB register file: half period and stop hold lengths.
// Depends on rsm_pkg.
module rsm_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rsm_pkg::cfg_t cfg_o
);

  logic [15:0] half_q, hold_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode on bit 2 only: word-aligned registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= rsm_pkg::HALF_PERIOD_RST;
      hold_q <= rsm_pkg::STOP_HOLD_RST;
    end else if (wr_en) begin
      if (paddr[2] == rsm_pkg::REG_HALF_PERIOD) begin
        half_q <= pwdata[15:0];
      end else begin
        hold_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rsm_pkg::REG_HALF_PERIOD) begin
      prdata = {16'h0000, half_q};
    end else begin
      prdata = {16'h0000, hold_q};
    end
  end

  assign cfg_o.half_period_ticks = half_q;
  assign cfg_o.stop_hold_ticks   = hold_q;

endmodule

// ===== hdl/rsm_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests off the input channel and classifies the command.
// Depends on rsm_pkg and rsm_req_if.
module rsm_front (
  rsm_req_if.sink       req_i,
  input  logic          q_full_i,
  output logic          push_o,
  output rsm_pkg::req_t item_o
);

  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && !q_full_i;

  always_comb begin
    item_o.command_word   = req_i.command_word;
    item_o.write_data     = req_i.write_data;
    item_o.first_of_burst = req_i.first_of_burst;
    item_o.sdata_in       = req_i.sdata_in;
    // Undefined codes become no-ops
    case (req_i.command)
      rsm_pkg::CMD_START: item_o.kind = rsm_pkg::KIND_START;
      rsm_pkg::CMD_WRITE: item_o.kind = rsm_pkg::KIND_WRITE;
      rsm_pkg::CMD_READ:  item_o.kind = rsm_pkg::KIND_READ;
      rsm_pkg::CMD_STOP:  item_o.kind = rsm_pkg::KIND_STOP;
      default:            item_o.kind = rsm_pkg::KIND_NONE;
    endcase
  end

endmodule

// ===== hdl/rsm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between front end and engine.
// Depends on rsm_pkg.
module rsm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsm_pkg::req_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output rsm_pkg::req_t item_o
);

  rsm_pkg::req_t                  mem_q [rsm_pkg::QDEPTH];
  logic [rsm_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [rsm_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == rsm_pkg::QCNT_W'(rsm_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/rsm_engine.sv =====
`timescale 1ns / 1ps
// Back end: bus sequencer stepped once per queued request tick, with an output
// register toward the result channel. Depends on rsm_pkg and rsm_res_if.
module rsm_engine #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsm_pkg::cfg_t cfg_i,
  input  logic          avail_i,
  input  rsm_pkg::req_t item_i,
  output logic          pop_o,
  rsm_res_if.source     res_o
);

  localparam int LW = (DIVIDER_WIDTH > 16) ? DIVIDER_WIDTH : 16;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_LOW0, PH_ST_HIGH, PH_ST_LOW1, PH_TX_HI, PH_TX_LO,
    PH_PK_A, PH_PK_B, PH_PK_C, PH_RX_HI, PH_RX_LO, PH_HOLD
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [DIVIDER_WIDTH-1:0] tick_q, tick_d;
  logic [3:0]               bit_q, bit_d;
  logic [11:0]              shift_q, shift_d;
  logic                     pacc_q, pacc_d;
  logic                     pflag_q, pflag_d;
  logic [7:0]               rbyte_q, rbyte_d;
  rsm_pkg::pins_t           pins_q, pins_d;
  logic                     res_valid_q;
  rsm_pkg::res_t            res_q, res_d;

  logic [DIVIDER_WIDTH-1:0] half_len, hold_len, seg_len;
  logic [DIVIDER_WIDTH:0]   tick_inc;
  logic                     busy, acc, rv, dat;
  logic [3:0]               bit_dec;

  function automatic logic [DIVIDER_WIDTH-1:0] clamp_len(input logic [15:0] v);
    logic [LW-1:0] ve;
    logic [LW-1:0] lim;
    ve  = LW'(v);
    lim = LW'({DIVIDER_WIDTH{1'b1}});
    if (ve == '0) ve = LW'(1);
    if (ve > lim) ve = lim;
    return DIVIDER_WIDTH'(ve);
  endfunction

  assign half_len = clamp_len(cfg_i.half_period_ticks);
  assign hold_len = clamp_len(cfg_i.stop_hold_ticks);

  assign pop_o = avail_i && (!res_valid_q || res_o.ready);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pacc_d  = pacc_q;
    pflag_d = pflag_q;
    rbyte_d = rbyte_q;
    acc     = 1'b0;
    rv      = 1'b0;
    dat     = 1'b0;

    // Take the request only while idle
    if (phase_q == PH_IDLE && item_i.kind != rsm_pkg::KIND_NONE) begin
      acc    = 1'b1;
      tick_d = '0;
      case (item_i.kind)
        rsm_pkg::KIND_START: begin
          pflag_d = 1'b0;
          shift_d = item_i.command_word;
          bit_d   = rsm_pkg::START_BITS;
          pacc_d  = 1'b0;
          phase_d = PH_ST_LOW0;
        end
        rsm_pkg::KIND_WRITE: begin
          shift_d = {item_i.write_data, 4'h0};
          bit_d   = rsm_pkg::BYTE_BITS;
          pacc_d  = 1'b0;
          phase_d = PH_TX_HI;
        end
        rsm_pkg::KIND_READ: begin
          shift_d = '0;
          bit_d   = rsm_pkg::BYTE_BITS;
          pacc_d  = 1'b1;
          phase_d = item_i.first_of_burst ? PH_PK_A : PH_RX_HI;
        end
        default: begin
          bit_d   = '0;
          phase_d = PH_PK_A;
        end
      endcase
    end

    busy   = (phase_d != PH_IDLE);
    pins_d = pins_q;
    case (phase_d)
      PH_ST_LOW0, PH_ST_LOW1: pins_d = '{drv: 1'b1, dat: 1'b0, clk: 1'b0};
      PH_ST_HIGH:             pins_d = '{drv: 1'b1, dat: 1'b1, clk: 1'b0};
      PH_TX_HI: begin
        dat    = (bit_d > 4'd1) ? shift_d[11] : !pacc_d;
        pins_d = '{drv: 1'b1, dat: dat, clk: 1'b1};
      end
      PH_TX_LO:               pins_d = '{drv: 1'b1, dat: pins_q.dat, clk: 1'b0};
      PH_PK_A:                pins_d.clk = 1'b1;
      PH_PK_B:                pins_d = '{drv: 1'b1, dat: 1'b0, clk: 1'b1};
      PH_RX_HI:               pins_d = '{drv: 1'b0, dat: 1'b0, clk: 1'b1};
      PH_PK_C, PH_RX_LO, PH_HOLD: pins_d = '{drv: 1'b0, dat: 1'b0, clk: 1'b0};
      default: ;
    endcase

    seg_len  = (phase_d == PH_HOLD) ? hold_len : half_len;
    tick_inc = {1'b0, tick_d} + (DIVIDER_WIDTH + 1)'(1);
    bit_dec  = (bit_d != '0) ? bit_d - 4'd1 : bit_d;

    if (busy) begin
      if (tick_inc < {1'b0, seg_len}) begin
        tick_d = tick_inc[DIVIDER_WIDTH-1:0];
      end else begin
        // Segment done: advance
        tick_d = '0;
        case (phase_d)
          PH_ST_LOW0: phase_d = PH_ST_HIGH;
          PH_ST_HIGH: phase_d = PH_ST_LOW1;
          PH_ST_LOW1: phase_d = PH_TX_HI;
          PH_TX_HI: begin
            if (bit_d > 4'd1) pacc_d = pacc_d ^ dat;
            phase_d = PH_TX_LO;
          end
          PH_TX_LO: begin
            shift_d = {shift_d[10:0], 1'b0};
            bit_d   = bit_dec;
            phase_d = (bit_dec != '0) ? PH_TX_HI : PH_IDLE;
          end
          PH_PK_A: phase_d = PH_PK_B;
          PH_PK_B: phase_d = PH_PK_C;
          PH_PK_C: begin
            if (bit_d != '0) begin
              phase_d = PH_RX_HI;
            end else begin
              phase_d = (cfg_i.stop_hold_ticks != '0) ? PH_HOLD : PH_IDLE;
            end
          end
          PH_RX_HI: begin
            if (bit_d > 4'd1) begin
              shift_d = {shift_d[10:0], item_i.sdata_in};
              pacc_d  = pacc_d ^ item_i.sdata_in;
            end else if (item_i.sdata_in != pacc_d) begin
              pflag_d = 1'b1;
            end
            phase_d = PH_RX_LO;
          end
          PH_RX_LO: begin
            bit_d = bit_dec;
            if (bit_dec == '0) begin
              rbyte_d = shift_d[7:0];
              rv      = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_RX_HI;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end

    res_d.sclk_level   = pins_d.clk;
    res_d.sdata_level  = pins_d.drv && pins_d.dat;
    res_d.sdata_drive  = pins_d.drv;
    res_d.busy_res     = busy;
    res_d.accepted     = acc;
    res_d.read_result  = rbyte_d;
    res_d.read_valid   = rv;
    res_d.parity_error = pflag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      pacc_q      <= 1'b0;
      pflag_q     <= 1'b0;
      rbyte_q     <= '0;
      pins_q      <= '{drv: 1'b1, dat: 1'b0, clk: 1'b0};
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      pacc_q      <= pacc_d;
      pflag_q     <= pflag_d;
      rbyte_q     <= rbyte_d;
      pins_q      <= pins_d;
      res_valid_q <= 1'b1;
      res_q       <= res_d;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.sclk_level   = res_q.sclk_level;
  assign res_o.sdata_level  = res_q.sdata_level;
  assign res_o.sdata_drive  = res_q.sdata_drive;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.accepted     = res_q.accepted;
  assign res_o.read_result  = res_q.read_result;
  assign res_o.read_valid   = res_q.read_valid;
  assign res_o.parity_error = res_q.parity_error;

endmodule

// ===== hdl/rffe_serial_master_top.sv =====
`timescale 1ns / 1ps
// Top level of the serial bus master: APB registers, front end, queue, engine.
// Depends on rsm_pkg, rsm_if, rsm_cfg, rsm_front, rsm_queue, rsm_engine.
//
// Usage:
//   req_i carries one bus tick per request: a command (start, write, read,
//   stop, or none) plus the sampled data pin level. res_o returns exactly one
//   result per request, in order: pin levels, busy, accepted, read byte,
//   read strobe and the sticky parity error.
//   A request passes through the queue entry and the engine's output register
//   before its result shows on res_o. Throughput: one request per cycle while
//   res_o.ready is high; the engine steps once per request.
//   A two-entry queue separates request intake from the engine; the output
//   register holds a result while res_o.ready is low, the queue keeps taking
//   requests until it fills, then req_i.ready drops.
//   Reset (rst_ni low, asynchronous) idles the sequencer, drives clock low
//   and data low, clears the queue and loads half period 4, stop hold 16.
//   Registers: 0x0 half_period_ticks, 0x4 stop_hold_ticks (16 bits each);
//   write only while no request is outstanding.
module rffe_serial_master_top #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsm_req_if.sink     req_i,
  rsm_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rsm_pkg::cfg_t cfg;
  rsm_pkg::req_t front_item, queue_item;
  logic          push, full, pop, avail;

  rsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsm_front u_front (
    .req_i    (req_i),
    .q_full_i (full),
    .push_o   (push),
    .item_o   (front_item)
  );

  rsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (queue_item)
  );

  rsm_engine #(
    .DIVIDER_WIDTH (DIVIDER_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .avail_i (avail),
    .item_i  (queue_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== hdl/rsm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the serial bus master.
// Bound to rffe_serial_master_top; no other dependencies.
module rsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic       sdata_level,
  input logic       sdata_drive,
  input logic       busy_res,
  input logic       accepted,
  input logic [7:0] read_result,
  input logic       read_valid,
  input logic       parity_error
);

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(read_result)
      && $stable(parity_error) && $stable(busy_res))
    else $error("result changed while stalled");

  a_drive_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !sdata_drive |-> !sdata_level)
    else $error("data level high while pin released");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && accepted |-> busy_res)
    else $error("accepted request not busy");

  a_rv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && read_valid |-> busy_res && !accepted)
    else $error("read strobe outside a running read");

endmodule

bind rffe_serial_master_top rsm_checker u_rsm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid    (res_o.valid),
  .res_ready    (res_o.ready),
  .sdata_level  (res_o.sdata_level),
  .sdata_drive  (res_o.sdata_drive),
  .busy_res     (res_o.busy_res),
  .accepted     (res_o.accepted),
  .read_result  (res_o.read_result),
  .read_valid   (res_o.read_valid),
  .parity_error (res_o.parity_error)
);
